// ----- rtl/size_class_bitmap_slot_allocator_unit_macros.svh -----
// Assertion macros for the slot allocator.
// SBSA_ASSERT_IMP: same-cycle implication. SBSA_ASSERT_NXT: next-cycle implication.
`ifndef SIZE_CLASS_BITMAP_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define SIZE_CLASS_BITMAP_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SBSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");
`define SBSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");
`else
`define SBSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SBSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/sbsa_pkg.sv -----
`default_nettype none
package sbsa_pkg;

	localparam int SLABS_PER_CLASS = 8;
	localparam int SLAB_BYTES      = 4096;
	localparam int NUM_CLASSES     = 5;
	localparam int HDR_BYTES       = 48;
	localparam int WORDS_PER_SLAB  = 4;
	localparam int MAX_SLOTS       = 256;
	localparam int WORD_BITS       = 64;

	localparam int BIT_W    = $clog2(WORD_BITS);
	localparam int WORD_W   = $clog2(WORDS_PER_SLAB);
	localparam int CLASS_W  = 3;
	localparam int SLAB_W   = 3;
	localparam int SLOT_W   = 8;
	localparam int CNT_W    = $clog2(SLABS_PER_CLASS + 1);
	localparam int CAP_W    = $clog2(MAX_SLOTS + 1);
	localparam int BUDGET_W = 6;
	localparam int REQ_W    = 32;
	localparam int STATUS_W = 3;

	localparam int RAM_DEPTH = NUM_CLASSES * SLABS_PER_CLASS * WORDS_PER_SLAB;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);

	localparam int CLASS_BYTES_0 = 16;
	localparam int CLASS_BYTES_1 = 32;
	localparam int CLASS_BYTES_2 = 48;
	localparam int CLASS_BYTES_3 = 64;
	localparam int CLASS_BYTES_4 = 128;

	localparam int CAP_RAW_0 = (SLAB_BYTES - HDR_BYTES) / CLASS_BYTES_0;
	localparam int CAP_RAW_1 = (SLAB_BYTES - HDR_BYTES) / CLASS_BYTES_1;
	localparam int CAP_RAW_2 = (SLAB_BYTES - HDR_BYTES) / CLASS_BYTES_2;
	localparam int CAP_RAW_3 = (SLAB_BYTES - HDR_BYTES) / CLASS_BYTES_3;
	localparam int CAP_RAW_4 = (SLAB_BYTES - HDR_BYTES) / CLASS_BYTES_4;

	localparam int CAP_0 = (CAP_RAW_0 > MAX_SLOTS) ? MAX_SLOTS : CAP_RAW_0;
	localparam int CAP_1 = (CAP_RAW_1 > MAX_SLOTS) ? MAX_SLOTS : CAP_RAW_1;
	localparam int CAP_2 = (CAP_RAW_2 > MAX_SLOTS) ? MAX_SLOTS : CAP_RAW_2;
	localparam int CAP_3 = (CAP_RAW_3 > MAX_SLOTS) ? MAX_SLOTS : CAP_RAW_3;
	localparam int CAP_4 = (CAP_RAW_4 > MAX_SLOTS) ? MAX_SLOTS : CAP_RAW_4;

	localparam logic [CAP_W-1:0] CLASS_CAP [NUM_CLASSES] = '{
		CAP_W'(CAP_0), CAP_W'(CAP_1), CAP_W'(CAP_2), CAP_W'(CAP_3), CAP_W'(CAP_4)
	};

	localparam logic [WORD_W-1:0] LAST_WORD [NUM_CLASSES] = '{
		WORD_W'((CAP_0 - 1) / WORD_BITS), WORD_W'((CAP_1 - 1) / WORD_BITS),
		WORD_W'((CAP_2 - 1) / WORD_BITS), WORD_W'((CAP_3 - 1) / WORD_BITS),
		WORD_W'((CAP_4 - 1) / WORD_BITS)
	};

	localparam logic [REQ_W-1:0] LIM_0 = REQ_W'(CLASS_BYTES_0);
	localparam logic [REQ_W-1:0] LIM_1 = REQ_W'(CLASS_BYTES_1);
	localparam logic [REQ_W-1:0] LIM_2 = REQ_W'(CLASS_BYTES_2);
	localparam logic [REQ_W-1:0] LIM_3 = REQ_W'(CLASS_BYTES_3);
	localparam logic [REQ_W-1:0] LIM_4 = REQ_W'(CLASS_BYTES_4);

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(40);

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_FREED     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_ZERO      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_TOO_LARGE = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NO_SLAB   = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_BAD_FREE  = 3'd5;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CLASS_W-1:0]  size_class;
		logic [SLAB_W-1:0]   slab_index;
		logic [SLOT_W-1:0]   slot_index;
	} result_t;

	typedef struct packed {
		logic                 hit;
		logic [BIT_W-1:0]     bit_idx;
	} find_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    addr;
		logic [WORD_BITS-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	function automatic logic [ADDR_W-1:0] word_addr(input logic [CLASS_W-1:0] cls,
			input logic [SLAB_W-1:0] slab, input logic [WORD_W-1:0] w);
		return ADDR_W'((int'(cls) * SLABS_PER_CLASS + int'(slab)) * WORDS_PER_SLAB + int'(w));
	endfunction

	// slots of the word that lie below the class capacity
	function automatic logic [WORD_BITS-1:0] word_mask(input logic [CAP_W-1:0] cap,
			input logic [WORD_W-1:0] w);
		logic [WORD_BITS-1:0] m;
		for (int i = 0; i < WORD_BITS; i++) begin
			m[i] = CAP_W'({w, BIT_W'(i)}) < cap;
		end
		return m;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/sbsa_channels.sv -----
`default_nettype none
interface sbsa_req_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [sbsa_pkg::REQ_W-1:0]    request_bytes;
	logic [sbsa_pkg::CLASS_W-1:0]  free_class;
	logic [sbsa_pkg::SLAB_W-1:0]   free_slab;
	logic [sbsa_pkg::SLOT_W-1:0]   free_slot;
	modport source(output valid, action, request_bytes, free_class, free_slab, free_slot,
		input ready);
	modport sink(input valid, action, request_bytes, free_class, free_slab, free_slot,
		output ready);
endinterface

interface sbsa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [sbsa_pkg::STATUS_W-1:0] status;
	logic [sbsa_pkg::CLASS_W-1:0]  size_class;
	logic [sbsa_pkg::SLAB_W-1:0]   slab_index;
	logic [sbsa_pkg::SLOT_W-1:0]   slot_index;
	modport source(output valid, status, size_class, slab_index, slot_index, input ready);
	modport sink(input valid, status, size_class, slab_index, slot_index, output ready);
endinterface

interface sbsa_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sbsa_pkg::BUDGET_W-1:0] slab_budget;
	modport source(output valid, slab_budget, input ready);
	modport sink(input valid, slab_budget, output ready);
endinterface
`default_nettype wire

// ----- rtl/size_class_bitmap_slot_allocator_unit.sv -----
// Channel  Dir  Beat
// req      in   action, request_bytes, free_class, free_slab, free_slot
// rsp      out  status, size_class, slab_index, slot_index
// cfg      in   slab_budget (always ready)
//
// Free: S_FREE_WR, then S_RESP; zero, oversized and bad requests: S_RESP directly.
// Allocate: S_SCAN over open slabs x bitmap words of the class (one bitmap RAM read
// a cycle), then S_OPEN when a new slab is opened and cleared word by word, then S_RESP.
// Reset clears counts and control only; a slab's words are cleared when it opens.
// req is held off while an item is in flight; a stalled rsp holds the result.
`default_nettype none
`include "size_class_bitmap_slot_allocator_unit_macros.svh"
module size_class_bitmap_slot_allocator_unit (
	input wire logic clk,
	input wire logic arst_n,
	sbsa_req_if.sink   req,
	sbsa_rsp_if.source rsp,
	sbsa_cfg_if.sink   cfg
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_OPEN    = 3'd2;
	localparam logic [2:0] S_FREE_WR = 3'd3;
	localparam logic [2:0] S_RESP    = 3'd4;

	logic [2:0]                        state_q;
	logic [sbsa_pkg::BUDGET_W-1:0]     budget_q;
	logic [sbsa_pkg::BUDGET_W-1:0]     opened_q;
	logic [sbsa_pkg::CNT_W-1:0]        cnt_q [sbsa_pkg::NUM_CLASSES];
	logic [sbsa_pkg::CLASS_W-1:0]      cls_q;
	logic                              iss_en_q;
	logic [sbsa_pkg::SLAB_W-1:0]       iss_slab_q;
	logic [sbsa_pkg::WORD_W-1:0]       iss_word_q;
	logic                              chk_v_s1;
	logic [sbsa_pkg::SLAB_W-1:0]       chk_slab_s1;
	logic [sbsa_pkg::WORD_W-1:0]       chk_word_s1;
	logic [sbsa_pkg::WORD_W-1:0]       open_w_q;
	logic [sbsa_pkg::ADDR_W-1:0]       fr_addr_q;
	logic [sbsa_pkg::BIT_W-1:0]        fr_bit_q;
	sbsa_pkg::result_t                 res_q;
	sbsa_pkg::result_t                 out_q;
	logic                              out_valid_q;

	logic                              req_fire;
	logic                              out_free;
	logic [sbsa_pkg::CLASS_W-1:0]      in_cls;
	logic [sbsa_pkg::CNT_W-1:0]        in_cnt;
	logic                              in_zero;
	logic                              in_large;
	logic                              free_cls_ok;
	logic                              free_ok;
	sbsa_pkg::result_t                 idle_res;
	logic [sbsa_pkg::CAP_W-1:0]        cur_cap;
	logic [sbsa_pkg::WORD_W-1:0]       last_w;
	logic [sbsa_pkg::CNT_W-1:0]        cnt_cur;
	logic [sbsa_pkg::WORD_BITS-1:0]    chk_mask;
	logic [sbsa_pkg::WORD_BITS-1:0]    ram_rdata;
	logic [sbsa_pkg::WORD_BITS-1:0]    one_hot_base;
	sbsa_pkg::find_t                   fnd;
	sbsa_pkg::ram_wr_t                 wr;
	sbsa_pkg::ram_rd_t                 rd;
	logic                              chk_last;
	logic                              scan_hit;
	logic                              scan_done;
	logic                              can_open;
	logic                              open_last;
	logic [sbsa_pkg::CNT_W+2:0]        cnt_sum;

	assign req_fire  = req.valid && req.ready;
	assign req.ready = state_q == S_IDLE;
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_q.status;
	assign rsp.size_class = out_q.size_class;
	assign rsp.slab_index = out_q.slab_index;
	assign rsp.slot_index = out_q.slot_index;

	assign one_hot_base = {{(sbsa_pkg::WORD_BITS-1){1'b0}}, 1'b1};

	always_comb begin
		in_zero  = req.request_bytes == '0;
		in_large = req.request_bytes > sbsa_pkg::LIM_4;
		if (req.request_bytes <= sbsa_pkg::LIM_0) begin
			in_cls = 3'd0;
		end else if (req.request_bytes <= sbsa_pkg::LIM_1) begin
			in_cls = 3'd1;
		end else if (req.request_bytes <= sbsa_pkg::LIM_2) begin
			in_cls = 3'd2;
		end else if (req.request_bytes <= sbsa_pkg::LIM_3) begin
			in_cls = 3'd3;
		end else begin
			in_cls = 3'd4;
		end
		in_cnt = cnt_q[in_cls];

		free_cls_ok = req.free_class < sbsa_pkg::CLASS_W'(sbsa_pkg::NUM_CLASSES);
		free_ok = free_cls_ok
			&& (sbsa_pkg::CNT_W'(req.free_slab) < cnt_q[req.free_class])
			&& (sbsa_pkg::CNT_W'(req.free_slab) < sbsa_pkg::CNT_W'(sbsa_pkg::SLABS_PER_CLASS))
			&& (sbsa_pkg::CAP_W'(req.free_slot) < sbsa_pkg::CLASS_CAP[req.free_class]);

		idle_res = '{sbsa_pkg::STAT_BAD_FREE, '0, '0, '0};
		if (req.action == sbsa_pkg::ACT_ALLOC) begin
			idle_res.status = in_zero ? sbsa_pkg::STAT_ZERO : sbsa_pkg::STAT_TOO_LARGE;
		end
	end

	always_comb begin
		cur_cap   = sbsa_pkg::CLASS_CAP[cls_q];
		last_w    = sbsa_pkg::LAST_WORD[cls_q];
		cnt_cur   = cnt_q[cls_q];
		chk_mask  = sbsa_pkg::word_mask(cur_cap, chk_word_s1);
		chk_last  = chk_slab_s1 == '0 && chk_word_s1 == last_w;
		scan_hit  = state_q == S_SCAN && chk_v_s1 && fnd.hit;
		scan_done = state_q == S_SCAN && (chk_v_s1 ? (!fnd.hit && chk_last) : !iss_en_q);
		can_open  = cnt_cur < sbsa_pkg::CNT_W'(sbsa_pkg::SLABS_PER_CLASS)
			&& opened_q < budget_q;
		open_last = open_w_q == sbsa_pkg::WORD_W'(sbsa_pkg::WORDS_PER_SLAB - 1);
	end

	always_comb begin
		rd.re   = 1'b0;
		rd.addr = '0;
		if (state_q == S_IDLE) begin
			rd.re   = req_fire && req.action == sbsa_pkg::ACT_FREE && free_ok;
			rd.addr = sbsa_pkg::word_addr(req.free_class, req.free_slab,
				req.free_slot[sbsa_pkg::BIT_W +: sbsa_pkg::WORD_W]);
		end else if (state_q == S_SCAN) begin
			rd.re   = iss_en_q;
			rd.addr = sbsa_pkg::word_addr(cls_q, iss_slab_q, iss_word_q);
		end
	end

	always_comb begin
		wr.we   = 1'b0;
		wr.addr = '0;
		wr.data = '0;
		if (state_q == S_FREE_WR) begin
			wr.we   = 1'b1;
			wr.addr = fr_addr_q;
			wr.data = ram_rdata & ~(one_hot_base << fr_bit_q);
		end else if (scan_hit) begin
			wr.we   = 1'b1;
			wr.addr = sbsa_pkg::word_addr(cls_q, chk_slab_s1, chk_word_s1);
			wr.data = ram_rdata | (one_hot_base << fnd.bit_idx);
		end else if (state_q == S_OPEN) begin
			// fresh slab: slot 0 taken, rest clear
			wr.we   = 1'b1;
			wr.addr = sbsa_pkg::word_addr(cls_q, sbsa_pkg::SLAB_W'(cnt_cur), open_w_q);
			wr.data = (open_w_q == '0) ? one_hot_base : '0;
		end
	end

	sbsa_bitmap_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rdata_q (ram_rdata)
	);

	sbsa_slot_find u_find (
		.word (ram_rdata),
		.mask (chk_mask),
		.res  (fnd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			budget_q    <= sbsa_pkg::BUDGET_RESET;
			opened_q    <= '0;
			for (int c = 0; c < sbsa_pkg::NUM_CLASSES; c++) begin
				cnt_q[c] <= '0;
			end
			iss_en_q    <= 1'b0;
			chk_v_s1    <= 1'b0;
			open_w_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				budget_q <= cfg.slab_budget;
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			chk_v_s1 <= state_q == S_SCAN && iss_en_q && !scan_hit;
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.action == sbsa_pkg::ACT_ALLOC) begin
							if (in_zero || in_large) begin
								state_q <= S_RESP;
							end else begin
								iss_en_q <= in_cnt != '0;
								state_q  <= S_SCAN;
							end
						end else begin
							state_q <= free_ok ? S_FREE_WR : S_RESP;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit || scan_done
							|| (iss_en_q && iss_word_q == last_w && iss_slab_q == '0)) begin
						iss_en_q <= 1'b0;
					end
					if (scan_hit) begin
						state_q  <= S_RESP;
					end else if (scan_done) begin
						open_w_q <= '0;
						state_q  <= can_open ? S_OPEN : S_RESP;
					end
				end
				S_OPEN: begin
					open_w_q <= open_w_q + 1'b1;
					if (open_last) begin
						cnt_q[cls_q] <= cnt_cur + 1'b1;
						opened_q     <= opened_q + 1'b1;
						state_q      <= S_RESP;
					end
				end
				S_FREE_WR: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_slab_s1 <= iss_slab_q;
		chk_word_s1 <= iss_word_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					cls_q      <= in_cls;
					iss_slab_q <= sbsa_pkg::SLAB_W'(in_cnt - 1'b1);
					iss_word_q <= '0;
					fr_addr_q  <= rd.addr;
					fr_bit_q   <= req.free_slot[sbsa_pkg::BIT_W-1:0];
					res_q      <= idle_res;
				end
			end
			S_SCAN: begin
				if (iss_en_q) begin
					if (iss_word_q == last_w) begin
						iss_word_q <= '0;
						iss_slab_q <= iss_slab_q - 1'b1;
					end else begin
						iss_word_q <= iss_word_q + 1'b1;
					end
				end
				if (scan_hit) begin
					res_q <= '{sbsa_pkg::STAT_ALLOCATED, cls_q, chk_slab_s1,
						sbsa_pkg::SLOT_W'({chk_word_s1, fnd.bit_idx})};
				end else if (scan_done) begin
					res_q <= '{sbsa_pkg::STAT_NO_SLAB, '0, '0, '0};
				end
			end
			S_OPEN: begin
				res_q <= '{sbsa_pkg::STAT_ALLOCATED, cls_q, sbsa_pkg::SLAB_W'(cnt_cur), '0};
			end
			S_FREE_WR: begin
				res_q <= '{sbsa_pkg::STAT_FREED, '0, '0, '0};
			end
			S_RESP: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cnt_sum = '0;
		for (int c = 0; c < sbsa_pkg::NUM_CLASSES; c++) begin
			cnt_sum = cnt_sum + (sbsa_pkg::CNT_W+3)'(cnt_q[c]);
		end
	end

	`SBSA_ASSERT_IMP(a_opened_matches_counts, clk, arst_n, 1'b1, cnt_sum == (sbsa_pkg::CNT_W+3)'(opened_q))
	`SBSA_ASSERT_IMP(a_open_allowed, clk, arst_n, state_q == S_OPEN, can_open)
	`SBSA_ASSERT_IMP(a_hit_below_cap, clk, arst_n, scan_hit, sbsa_pkg::CAP_W'({chk_word_s1, fnd.bit_idx}) < cur_cap)
	`SBSA_ASSERT_NXT(a_resp_loads_out, clk, arst_n, state_q == S_RESP && out_free, rsp.valid && state_q == S_IDLE)

endmodule
`default_nettype wire

// ----- rtl/sbsa_bitmap_ram.sv -----
`default_nettype none
module sbsa_bitmap_ram (
	input  wire logic                               clk,
	input  wire sbsa_pkg::ram_wr_t                  wr,
	input  wire sbsa_pkg::ram_rd_t                  rd,
	output logic [sbsa_pkg::WORD_BITS-1:0]          rdata_q
);

	logic [sbsa_pkg::WORD_BITS-1:0] mem [sbsa_pkg::RAM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			rdata_q <= mem[rd.addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/sbsa_slot_find.sv -----
`default_nettype none
module sbsa_slot_find (
	input  wire logic [sbsa_pkg::WORD_BITS-1:0] word,
	input  wire logic [sbsa_pkg::WORD_BITS-1:0] mask,
	output sbsa_pkg::find_t                     res
);

	localparam int GRP   = 8;
	localparam int NGRP  = sbsa_pkg::WORD_BITS / GRP;
	localparam int GRP_W = $clog2(GRP);
	localparam int SEL_W = sbsa_pkg::BIT_W - GRP_W;

	logic [sbsa_pkg::WORD_BITS-1:0] avail;
	logic [NGRP-1:0]                grp_nz;
	logic [SEL_W-1:0]               grp_sel;
	logic [GRP-1:0]                 grp_bits;
	logic [GRP_W-1:0]               bit_sel;

	// lowest free slot: first the group, then the bit within it
	always_comb begin
		avail = ~word & mask;
		for (int g = 0; g < NGRP; g++) begin
			grp_nz[g] = |avail[g*GRP +: GRP];
		end
		grp_sel = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_nz[g]) begin
				grp_sel = SEL_W'(g);
			end
		end
		grp_bits = avail[{grp_sel, {GRP_W{1'b0}}} +: GRP];
		bit_sel = '0;
		for (int b = GRP - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				bit_sel = GRP_W'(b);
			end
		end
		res.hit     = |grp_nz;
		res.bit_idx = {grp_sel, bit_sel};
	end

endmodule
`default_nettype wire
